// ----- design/assert_macros.svh -----
// Assertion macros shared by the filter RTL.
// No dependencies; the files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at each rising edge outside reset
`define VAF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication
`define VAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define VAF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VAF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/vaf_pkg.sv -----
// Shared constants and types for the 3x3 adaptive noise reduction filter.
// No dependencies; used by vaf_chan and the top level.
`default_nettype none
package vaf_pkg;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int SAMPLE_W       = 8;
    localparam int NOISE_W        = 21;
    localparam int WIDTH_REG_W    = 11;
    localparam int POS_W          = 10;
    localparam int CMP_W          = 13;
    // register stages inside one channel unit, window to result
    localparam int CHAN_LAT       = 13;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [NOISE_W-1:0]  noise_t;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH = 2'd0,
        REG_NOISE_RED   = 2'd1,
        REG_NOISE_GREEN = 2'd2,
        REG_NOISE_BLUE  = 2'd3
    } cfg_reg_t;
endpackage
`default_nettype wire

// ----- design/variance_adaptive_filter_3x3.sv -----
// Top level of the 3x3 adaptive noise reduction filter: stream ports, APB
// registers, line store and window. Depends on vaf_pkg, vaf_chan, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
// Takes one RGB pixel per clock in raster order and gives one filtered pixel
// per clock once the window is primed, while the output is not stalled;
// every pixel from the second row and second column on yields the pixel one
// row up and one column left. A result passes through the line store read
// and window update, the per-channel arithmetic (statistics, multiplier stages
// and an eight-stage restoring divider) and the output register. Output
// backpressure stalls the whole pipe. Line store contents are not cleared at
// reset, so no clearing pass is needed.
module variance_adaptive_filter_3x3
    import vaf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red_in, green_in, blue_in
    input  wire logic        s_tuser,   // frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // red_out, green_out, blue_out, out_column, out_row
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // configuration registers
    logic [WIDTH_REG_W-1:0] image_width_reg;
    noise_t                 noise_red_reg;
    noise_t                 noise_green_reg;
    noise_t                 noise_blue_reg;
    cfg_reg_t               reg_sel;
    logic                   cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = cfg_reg_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= WIDTH_REG_W'(1024);
            noise_red_reg   <= '0;
            noise_green_reg <= '0;
            noise_blue_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_IMAGE_WIDTH: image_width_reg <= pwdata[WIDTH_REG_W-1:0];
                REG_NOISE_RED:   noise_red_reg   <= pwdata[NOISE_W-1:0];
                REG_NOISE_GREEN: noise_green_reg <= pwdata[NOISE_W-1:0];
                REG_NOISE_BLUE:  noise_blue_reg  <= pwdata[NOISE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_IMAGE_WIDTH: prdata = 32'(image_width_reg);
            REG_NOISE_RED:   prdata = 32'(noise_red_reg);
            REG_NOISE_GREEN: prdata = 32'(noise_green_reg);
            REG_NOISE_BLUE:  prdata = 32'(noise_blue_reg);
            default:         prdata = '0;
        endcase
    end

    // pipeline advance: the output register is free or being drained
    logic en;
    logic accept;
    logic m_valid_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    // position counters
    logic [CW-1:0]    col_cnt_reg;
    logic [RW-1:0]    row_cnt_reg;
    logic [CMP_W-1:0] w_eff;
    logic [CW-1:0]    col_start;
    logic [RW-1:0]    row_start;
    logic [CMP_W-1:0] col_plus;
    logic [CW-1:0]    col_next;
    logic [RW-1:0]    row_next;

    function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
        row_inc = (r < RW'(MAX_HEIGHT - 1)) ? r + RW'(1) : r;
    endfunction

    always_comb
    begin
        if (CMP_W'(image_width_reg) < CMP_W'(3))
            w_eff = CMP_W'(3);
        else if (CMP_W'(image_width_reg) > CMP_W'(MAX_WIDTH))
            w_eff = CMP_W'(MAX_WIDTH);
        else
            w_eff = CMP_W'(image_width_reg);

        if (s_tuser)
        begin
            col_start = '0;
            row_start = '0;
        end
        else if (CMP_W'(col_cnt_reg) >= w_eff)
        begin
            col_start = '0;
            row_start = row_inc(row_cnt_reg);
        end
        else
        begin
            col_start = col_cnt_reg;
            row_start = row_cnt_reg;
        end

        col_plus = CMP_W'(col_start) + CMP_W'(1);
        if (col_plus >= w_eff)
        begin
            col_next = '0;
            row_next = row_inc(row_start);
        end
        else
        begin
            col_next = CW'(col_plus);
            row_next = row_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (accept)
        begin
            col_cnt_reg <= col_next;
            row_cnt_reg <= row_next;
        end
    end

    // stage 0: accepted pixel, line store read in flight
    logic             s0_valid_reg;
    logic             s0_emit_reg;
    logic             s0_border_reg;
    logic [CW-1:0]    s0_col_reg;
    logic [POS_W-1:0] s0_oc_reg;
    logic [POS_W-1:0] s0_or_reg;
    logic [23:0]      s0_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_emit_reg   <= (row_start != '0) && (col_start != '0);
            s0_border_reg <= (col_start == CW'(1)) || (row_start == RW'(1));
            s0_col_reg    <= col_start;
            s0_oc_reg     <= POS_W'(col_start - CW'(1));
            s0_or_reg     <= POS_W'(row_start - RW'(1));
            s0_pix_reg    <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
        end
    end

    // line store: upper row in the high half, lower row in the low half
    logic [47:0] line_mem [MAX_WIDTH];
    logic [47:0] rd_reg;
    logic [47:0] fwd_data_reg;
    logic        fwd_hit_reg;
    logic [23:0] up_eff;
    logic [23:0] lo_eff;

    assign up_eff = fwd_hit_reg ? fwd_data_reg[47:24] : rd_reg[47:24];
    assign lo_eff = fwd_hit_reg ? fwd_data_reg[23:0]  : rd_reg[23:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_reg <= line_mem[col_start];
            // write at the same column as the new read: pass it on
            fwd_hit_reg  <= s0_valid_reg && (s0_col_reg == col_start);
            fwd_data_reg <= {lo_eff, s0_pix_reg};
            if (s0_valid_reg)
                line_mem[s0_col_reg] <= {lo_eff, s0_pix_reg};
        end
    end

    // 3x3 window, newest column on the right
    logic [23:0] win_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= '0;
        end
        else if (en && s0_valid_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k*3]     <= win_reg[k*3+1];
                win_reg[k*3+1]   <= win_reg[k*3+2];
            end
            win_reg[2] <= up_eff;
            win_reg[5] <= lo_eff;
            win_reg[8] <= s0_pix_reg;
        end
    end

    // request tags travelling alongside the channel units
    logic [CHAN_LAT:0] pipe_emit_reg;
    logic [CHAN_LAT:0] pipe_border_reg;
    logic [POS_W-1:0]  pipe_oc_reg [CHAN_LAT+1];
    logic [POS_W-1:0]  pipe_or_reg [CHAN_LAT+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pipe_emit_reg <= '0;
        else if (en)
            pipe_emit_reg <= {pipe_emit_reg[CHAN_LAT-1:0], s0_valid_reg && s0_emit_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_border_reg <= {pipe_border_reg[CHAN_LAT-1:0], s0_border_reg};
            pipe_oc_reg[0]  <= s0_oc_reg;
            pipe_or_reg[0]  <= s0_or_reg;
            for (int i = 1; i <= CHAN_LAT; i++)
            begin
                pipe_oc_reg[i] <= pipe_oc_reg[i-1];
                pipe_or_reg[i] <= pipe_or_reg[i-1];
            end
        end
    end

    // per-channel arithmetic
    sample_t win_r [9];
    sample_t win_g [9];
    sample_t win_b [9];
    sample_t res_r;
    sample_t res_g;
    sample_t res_b;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            win_r[k] = win_reg[k][23:16];
            win_g[k] = win_reg[k][15:8];
            win_b[k] = win_reg[k][7:0];
        end
    end

    vaf_chan u_chan_r (.clk(clk), .rst_n(rst_n), .en(en), .win(win_r),
                       .noise(noise_red_reg), .res(res_r));
    vaf_chan u_chan_g (.clk(clk), .rst_n(rst_n), .en(en), .win(win_g),
                       .noise(noise_green_reg), .res(res_g));
    vaf_chan u_chan_b (.clk(clk), .rst_n(rst_n), .en(en), .win(win_b),
                       .noise(noise_blue_reg), .res(res_b));

    // output register
    logic [47:0] m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= pipe_emit_reg[CHAN_LAT];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_data_reg[23:0]  <= pipe_border_reg[CHAN_LAT] ? 24'd0 : {res_b, res_g, res_r};
            m_data_reg[33:24] <= pipe_oc_reg[CHAN_LAT];
            m_data_reg[43:34] <= pipe_or_reg[CHAN_LAT];
            m_data_reg[47:44] <= '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    logic out_on_border;
    logic out_stalled;

    assign out_on_border = m_tvalid && (m_tdata[33:24] == 10'd0 || m_tdata[43:34] == 10'd0);
    assign out_stalled   = m_tvalid && !m_tready;

    `VAF_ASSERT_IMP(a_border_zero, clk, rst_n, out_on_border, m_tdata[23:0] == 24'd0)
    `VAF_ASSERT_IMP(a_row_limit, clk, rst_n, 1'b1, row_cnt_reg <= RW'(MAX_HEIGHT - 1))
    `VAF_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_stalled,
                     $stable(pipe_emit_reg) && $stable(col_cnt_reg))
endmodule
`default_nettype wire

// ----- design/vaf_chan.sv -----
// One colour channel of the filter: window statistics, weighting and an
// eight-stage restoring divider. Depends on vaf_pkg.
`default_nettype none
module vaf_chan
    import vaf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    en,
    input  wire sample_t win [9],
    input  wire noise_t  noise,
    output sample_t      res
);
    // stage 1: squares, sum, centre
    logic [15:0] sq_reg [9];
    logic [11:0] s1_reg;
    sample_t     p1_reg;
    // stage 2: Q, S*S, 9p-S
    logic [19:0]        q2_reg;
    logic [23:0]        ss2_reg;
    logic signed [12:0] e2_reg;
    logic [11:0]        s2_reg;
    sample_t            p2_reg;
    // stage 3: V, D
    logic [23:0]        v3_reg;
    logic [23:0]        d3_reg;
    logic signed [12:0] e3_reg;
    logic [11:0]        s3_reg;
    sample_t            p3_reg;
    // stage 4: products
    logic [35:0]        a4_reg;
    logic signed [37:0] b4_reg;
    logic [27:0]        d94_reg;
    logic               dz4_reg;
    sample_t            p4_reg;
    // divider stages, index 0 holds the clamped numerator
    logic [37:0] rem_reg [9];
    logic [7:0]  quo_reg [9];
    logic [27:0] d9_reg  [9];
    logic [8:0]  dz_reg;
    logic [8:0]  sat_reg;
    sample_t     pd_reg  [9];

    logic [11:0]        s_sum;
    logic [19:0]        q_sum;
    logic [11:0]        p9;
    logic [23:0]        v_next;
    logic [37:0]        num;
    logic [37:0]        num_clamp;
    logic [37:0]        trial [9];
    logic               fits  [9];
    logic               unused_rst;

    assign unused_rst = rst_n;

    // window sum and sum of squares, 9p, variance and the numerator clamped at zero
    always_comb
    begin
        s_sum = '0;
        q_sum = '0;
        for (int k = 0; k < 9; k++)
        begin
            s_sum = s_sum + 12'(win[k]);
            q_sum = q_sum + 20'(sq_reg[k]);
        end
        p9     = (12'(p1_reg) << 3) + 12'(p1_reg);
        v_next = ((24'(q2_reg) << 3) + 24'(q2_reg)) - ss2_reg;
        num    = $signed({2'b00, a4_reg}) + b4_reg;
        num_clamp = num[37] ? '0 : num;
    end

    // trial subtraction for each quotient bit, most significant first
    always_comb
    begin
        trial[0] = '0;
        fits[0]  = 1'b0;
        for (int i = 1; i < 9; i++)
        begin
            trial[i] = 38'(d9_reg[i-1]) << (8 - i);
            fits[i]  = rem_reg[i-1] >= trial[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
                sq_reg[k] <= 16'(win[k]) * 16'(win[k]);
            s1_reg <= s_sum;
            p1_reg <= win[4];

            q2_reg  <= q_sum;
            ss2_reg <= 24'(s1_reg) * 24'(s1_reg);
            e2_reg  <= $signed({1'b0, p9}) - $signed({1'b0, s1_reg});
            s2_reg  <= s1_reg;
            p2_reg  <= p1_reg;

            v3_reg <= v_next;
            d3_reg <= v_next + 24'(noise);
            e3_reg <= e2_reg;
            s3_reg <= s2_reg;
            p3_reg <= p2_reg;

            a4_reg  <= 36'(s3_reg) * 36'(d3_reg);
            b4_reg  <= 38'($signed({1'b0, v3_reg}) * e3_reg);
            d94_reg <= (28'(d3_reg) << 3) + 28'(d3_reg);
            dz4_reg <= (d3_reg == '0);
            p4_reg  <= p3_reg;

            rem_reg[0] <= num_clamp;
            quo_reg[0] <= '0;
            d9_reg[0]  <= d94_reg;
            dz_reg[0]  <= dz4_reg;
            sat_reg[0] <= num_clamp >= (38'(d94_reg) << 8);
            pd_reg[0]  <= p4_reg;

            for (int i = 1; i < 9; i++)
            begin
                rem_reg[i] <= fits[i] ? rem_reg[i-1] - trial[i] : rem_reg[i-1];
                quo_reg[i] <= {quo_reg[i-1][6:0], fits[i]};
                d9_reg[i]  <= d9_reg[i-1];
                dz_reg[i]  <= dz_reg[i-1];
                sat_reg[i] <= sat_reg[i-1];
                pd_reg[i]  <= pd_reg[i-1];
            end
        end
    end

    // zero denominator passes the centre sample through
    assign res = dz_reg[8] ? pd_reg[8] : (sat_reg[8] ? 8'hFF : quo_reg[8]);
endmodule
`default_nettype wire

// ----- dv/tb_variance_adaptive_filter_3x3.sv -----
// Testbench for the 3x3 adaptive noise reduction filter: drives RGB pixel
// frames and APB register writes, predicts every result and checks it.
// Depends on vaf_pkg and variance_adaptive_filter_3x3.
`timescale 1ns / 100ps
`default_nettype none

// Expected filtered pixel
typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] col;
    logic [9:0] row;
} vaf_pixel_t;

// Keeps its own copy of the filter state and queues expected pixels
class vaf_scoreboard;
    logic [23:0] upper_line [1024];
    logic [23:0] lower_line [1024];
    logic [23:0] win [9];
    int unsigned col_cnt, row_cnt;
    int unsigned width_reg;
    int unsigned noise [3];
    vaf_pixel_t expected_pixels [$];
    int errors;

    function new();
        foreach (win[k]) win[k] = '0;
        foreach (upper_line[k]) upper_line[k] = '0;
        foreach (lower_line[k]) lower_line[k] = '0;
        col_cnt = 0;
        row_cnt = 0;
        width_reg = 1024;
        noise[0] = 0; noise[1] = 0; noise[2] = 0;
        errors = 0;
    endfunction

    function int unsigned active_width();
        if (width_reg < 3) return 3;
        if (width_reg > 1024) return 1024;
        return width_reg;
    endfunction

    function void advance_row();
        col_cnt = 0;
        if (row_cnt < 1023) row_cnt++;
    endfunction

    // Local variance weighted blend of window mean and centre sample
    function logic [7:0] blend(int sh, int unsigned nv);
        longint s, q, p, v, d, num, res, x;
        s = 0;
        q = 0;
        for (int k = 0; k < 9; k++) begin
            x = (win[k] >> sh) & 8'hff;
            s += x;
            q += x * x;
        end
        p = (win[4] >> sh) & 8'hff;
        v = 9 * q - s * s;
        d = v + longint'(nv);
        if (d == 0) return p[7:0];
        num = s * d + v * (9 * p - s);
        if (num < 0) num = 0;
        res = num / (9 * d);
        if (res > 255) res = 255;
        return res[7:0];
    endfunction

    // pix holds red in bits 23:16, green in 15:8, blue in 7:0
    function void note_request(logic [23:0] pix, logic fs);
        int unsigned w, c, r;
        logic [23:0] up, lo;
        vaf_pixel_t e;
        w = active_width();
        if (fs) begin
            col_cnt = 0;
            row_cnt = 0;
        end else if (col_cnt >= w) begin
            advance_row();
        end
        c = col_cnt;
        r = row_cnt;
        up = upper_line[c];
        lo = lower_line[c];
        upper_line[c] = lo;
        lower_line[c] = pix;
        for (int k = 0; k < 3; k++) begin
            win[k*3] = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2] = up;
        win[5] = lo;
        win[8] = pix;
        if (r >= 1 && c >= 1) begin
            e.col = 10'(c - 1);
            e.row = 10'(r - 1);
            if (c == 1 || r == 1) begin
                e.red = 0; e.green = 0; e.blue = 0;
            end else begin
                e.red = blend(16, noise[0]);
                e.green = blend(8, noise[1]);
                e.blue = blend(0, noise[2]);
            end
            expected_pixels.push_back(e);
        end
        col_cnt = c + 1;
        if (col_cnt >= w) advance_row();
    endfunction

    function void check_result(logic [47:0] data);
        vaf_pixel_t e;
        if (expected_pixels.size() == 0) begin
            $error("unexpected result %h", data);
            errors++;
            return;
        end
        e = expected_pixels.pop_front();
        if (data[7:0] !== e.red) begin
            $error("red_out exp %0d got %0d", e.red, data[7:0]); errors++;
        end
        if (data[15:8] !== e.green) begin
            $error("green_out exp %0d got %0d", e.green, data[15:8]); errors++;
        end
        if (data[23:16] !== e.blue) begin
            $error("blue_out exp %0d got %0d", e.blue, data[23:16]); errors++;
        end
        if (data[33:24] !== e.col) begin
            $error("out_column exp %0d got %0d", e.col, data[33:24]); errors++;
        end
        if (data[43:34] !== e.row) begin
            $error("out_row exp %0d got %0d", e.row, data[43:34]); errors++;
        end
    endfunction
endclass

module tb_variance_adaptive_filter_3x3;
    import vaf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [23:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    vaf_scoreboard filter_model = new();
    int idle_cycles = 0;
    bit long_hold = 1'b0;
    int stall_mode = 0;

    variance_adaptive_filter_3x3 dut (.*);

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predict on accepted requests, check accepted results; red sits in the
    // low byte of s_tdata, the model keeps it in the high byte
    always @(posedge clk) begin
        if (rst_n && s_tvalid && s_tready)
            filter_model.note_request({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}, s_tuser);
        if (rst_n && m_tvalid && m_tready) filter_model.check_result(m_tdata);
    end

    // Receiver stall pattern with a long hold-off on request
    always @(posedge clk) begin
        if (long_hold) m_tready <= 1'b0;
        else case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 1) != 0);
        endcase
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    end

    // Watchdog on cycles with no transfer
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_variance_adaptive_filter_3x3 NOT OK");
            $finish;
        end
    end

    task automatic reg_write(cfg_reg_t idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 4'(idx) << 2; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH: filter_model.width_reg = val & 32'h7ff;
            REG_NOISE_RED:   filter_model.noise[0] = val & 32'h1fffff;
            REG_NOISE_GREEN: filter_model.noise[1] = val & 32'h1fffff;
            default:         filter_model.noise[2] = val & 32'h1fffff;
        endcase
    endtask

    // Offer one pixel and hold it until taken; bursty gaps before it
    task automatic send_pixel(logic [23:0] pix, logic fs, bit gaps);
        if (gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pix;
        s_tuser <= fs;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        s_tuser <= 1'b0;
    endtask

    // Wait until every prediction has been matched, then let the pipe drain
    task automatic drain();
        stop_sending();
        while (filter_model.expected_pixels.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic send_frame(int w, int h, int mode, bit gaps);
        logic [23:0] pix;
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++) begin
                case (mode)
                    0: pix = {$urandom} & 24'hffffff;
                    1: pix = ($urandom_range(0, 1) != 0) ? 24'hffffff : 24'h000000;
                    2: pix = 24'h808080 ^ ({$urandom} & 24'h070707);
                    default: pix = {3{8'(r * 37 + c * 11)}};
                endcase
                send_pixel(pix, (r == 0 && c == 0), gaps);
            end
    endtask

    initial begin
        int w, h;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: flat frame with zero red noise (zero denominator), extremes
        reg_write(REG_IMAGE_WIDTH, 3);
        reg_write(REG_NOISE_RED, 0);
        reg_write(REG_NOISE_GREEN, 1327104);
        reg_write(REG_NOISE_BLUE, 1);
        for (int k = 0; k < 9; k++) send_pixel(24'h7f7f7f, k == 0, 1'b0);
        send_pixel(24'hffffff, 1'b1, 1'b0);
        for (int k = 1; k < 9; k++)
            send_pixel((k == 4) ? 24'h000000 : 24'hff00ff, 1'b0, 1'b0);
        // width below the minimum acts as three
        drain();
        reg_write(REG_IMAGE_WIDTH, 1);
        send_frame(3, 2, 1, 1'b0);
        drain();

        // Random frames with varied widths and noise settings
        for (int f = 0; f < 18; f++) begin
            w = $urandom_range(3, 9);
            h = $urandom_range(3, 7);
            // the long receiver hold needs a frame big enough to fill the pipe
            if (f == 2)
            begin
                w = 9;
                h = 7;
            end
            reg_write(REG_IMAGE_WIDTH, (f == 9) ? 2047 : w);
            // oversized width acts as the maximum: a long partial top row
            if (f == 9)
            begin
                w = 40;
                h = 1;
            end
            reg_write(REG_NOISE_RED, $urandom_range(0, 1327104));
            reg_write(REG_NOISE_GREEN, (f % 3 == 0) ? 0 : $urandom_range(0, 5000));
            reg_write(REG_NOISE_BLUE, (f % 4 == 1) ? 1327104 : $urandom_range(0, 300));
            stall_mode = f % 3;
            if (f == 2) fork
                begin
                    long_hold = 1'b1;
                    repeat (200) @(posedge clk);
                    long_hold = 1'b0;
                end
            join_none
            send_frame(w, h, $urandom_range(0, 3), f != 4);
            // noise: an unflagged pixel restarts nothing, a stray frame start
            if (f == 7) begin
                send_pixel({$urandom} & 24'hffffff, 1'b1, 1'b1);
                send_pixel({$urandom} & 24'hffffff, 1'b0, 1'b1);
            end
            drain();
        end

        if (filter_model.errors == 0)
            $display("tb_variance_adaptive_filter_3x3 OK");
        else
            $display("tb_variance_adaptive_filter_3x3 NOT OK");
        $finish;
    end
endmodule
